// ----- rtl/fptlb_pkg.sv -----
// shared constants and types of the page translation buffer
package fptlb_pkg;

  // field widths
  localparam int unsigned PageW   = 31;
  localparam int unsigned OffsetW = 24;
  localparam int unsigned FrameW  = 16;
  localparam int unsigned AddrW   = 48;
  localparam int unsigned PbW     = 5;
  localparam int unsigned CfgW    = 48;

  // default number of buffer slots
  localparam int unsigned EntriesDefault = 5;

  // usable page size range, log2 bytes
  localparam logic [PbW-1:0] PbMin   = 5'd12;
  localparam logic [PbW-1:0] PbMax   = 5'd24;
  localparam logic [PbW-1:0] PbReset = 5'd12;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_PAGE_BITS  = 1'b0,
    CFG_CACHE_BASE = 1'b1
  } cfg_idx_e;

  // one lookup request as held in the input register
  typedef struct packed {
    logic [PageW-1:0]   page_index;
    logic [OffsetW-1:0] byte_offset;
    logic               write_access;
    logic [FrameW-1:0]  fill_frame;
  } req_t;

  // one lookup result as held in the output register
  typedef struct packed {
    logic               hit;
    logic [AddrW-1:0]   cache_address;
    logic               victim_valid;
    logic [PageW-1:0]   victim_page;
    logic               victim_dirty;
  } rsp_t;

endpackage

// ----- rtl/fptlb_if.sv -----
// valid/ready channel interfaces for lookup requests and results

interface fptlb_req_if
  import fptlb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PageW-1:0]   page_index;
  logic [OffsetW-1:0] byte_offset;
  logic               write_access;
  logic [FrameW-1:0]  fill_frame;

  modport source (
    output valid, page_index, byte_offset, write_access, fill_frame,
    input  ready
  );
  modport sink (
    input  valid, page_index, byte_offset, write_access, fill_frame,
    output ready
  );
endinterface

interface fptlb_rsp_if
  import fptlb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [AddrW-1:0] cache_address;
  logic             victim_valid;
  logic [PageW-1:0] victim_page;
  logic             victim_dirty;

  modport source (
    output valid, hit, cache_address, victim_valid, victim_page, victim_dirty,
    input  ready
  );
  modport sink (
    input  valid, hit, cache_address, victim_valid, victim_page, victim_dirty,
    output ready
  );
endinterface

// ----- rtl/fifo_page_tlb_with_dirty.sv -----
// top level of the fully associative page translation buffer
//
// Fully associative translation buffer with FIFO replacement and per-entry
// dirty marks. Every request transaction gives exactly one result transaction.
// A request is captured in an input register; when the output register is
// free or being read, all slots are compared in parallel, the slots are
// updated (dirty mark on a hit, shift in on a miss) and the result is written
// into the output register, which offers it on the result channel. One
// request is accepted per cycle as long as the result side keeps taking
// results; the rate is set by the single compare-and-update stage that
// touches the slot registers. All slots are invalid after reset, no clearing
// pass is needed. Configuration writes take effect at once and are meant for
// idle periods; page_bits is clamped to 12..24 and the offset is masked to
// the page size.
module fifo_page_tlb_with_dirty
  import fptlb_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration write port
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  // request and result channels
  fptlb_req_if.sink       req_i,
  fptlb_rsp_if.source     rsp_o
);

  // configuration registers
  logic [PbW-1:0]   page_bits_q;
  logic [AddrW-1:0] cache_base_q;

  // input register
  logic in_valid_q;
  req_t in_q;

  // output register
  logic rsp_valid_q;
  rsp_t rsp_q, rsp_d;

  // slot storage, slot 0 newest
  logic [PageW-1:0]  entry_page_q  [ENTRIES];
  logic [FrameW-1:0] entry_frame_q [ENTRIES];
  logic [ENTRIES-1:0] entry_valid_q, entry_valid_d;
  logic [ENTRIES-1:0] entry_dirty_q, entry_dirty_d;

  // lookup signals
  logic [ENTRIES-1:0] match;
  logic               hit;
  logic [FrameW-1:0]  sel_frame;
  logic [PbW-1:0]     eff_pb;
  logic [OffsetW-1:0] off_mask;
  logic [AddrW-1:0]   frame_off;
  logic               advance;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_bits_q  <= PbReset;
      cache_base_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PAGE_BITS:  page_bits_q  <= cfg_data_i[PbW-1:0];
        CFG_CACHE_BASE: cache_base_q <= cfg_data_i[AddrW-1:0];
      endcase
    end
  end

  // pipeline handshake
  assign advance     = in_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.page_index   <= req_i.page_index;
      in_q.byte_offset  <= req_i.byte_offset;
      in_q.write_access <= req_i.write_access;
      in_q.fill_frame   <= req_i.fill_frame;
    end
  end

  // parallel tag compare with lowest slot winning
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = entry_valid_q[i] && (entry_page_q[i] == in_q.page_index);
    end
    hit       = |match;
    sel_frame = in_q.fill_frame;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        sel_frame = entry_frame_q[i];
      end
    end
  end

  // address build: frame and masked offset do not overlap, so one add remains
  always_comb begin
    if (page_bits_q < PbMin) begin
      eff_pb = PbMin;
    end else if (page_bits_q > PbMax) begin
      eff_pb = PbMax;
    end else begin
      eff_pb = page_bits_q;
    end
    off_mask  = ~({OffsetW{1'b1}} << eff_pb);
    frame_off = ({{(AddrW-FrameW){1'b0}}, sel_frame} << eff_pb)
              | {{(AddrW-OffsetW){1'b0}}, in_q.byte_offset & off_mask};
  end

  // result assembly
  always_comb begin
    rsp_d.hit           = hit;
    rsp_d.cache_address = cache_base_q + frame_off;
    if (!hit && entry_valid_q[ENTRIES-1]) begin
      rsp_d.victim_valid = 1'b1;
      rsp_d.victim_page  = entry_page_q[ENTRIES-1];
      rsp_d.victim_dirty = entry_dirty_q[ENTRIES-1];
    end else begin
      rsp_d.victim_valid = 1'b0;
      rsp_d.victim_page  = '0;
      rsp_d.victim_dirty = 1'b0;
    end
  end

  // slot control update: dirty mark on hit, shift in on miss
  always_comb begin
    entry_valid_d = entry_valid_q;
    entry_dirty_d = entry_dirty_q;
    if (hit) begin
      entry_dirty_d = entry_dirty_q | (match & {ENTRIES{in_q.write_access}});
    end else begin
      for (int i = ENTRIES - 1; i > 0; i--) begin
        entry_valid_d[i] = entry_valid_q[i-1];
        entry_dirty_d[i] = entry_dirty_q[i-1];
      end
      entry_valid_d[0] = 1'b1;
      entry_dirty_d[0] = in_q.write_access;
    end
  end

  // slot valid and dirty bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      entry_dirty_q <= '0;
    end else if (advance) begin
      entry_valid_q <= entry_valid_d;
      entry_dirty_q <= entry_dirty_d;
    end
  end

  // slot page and frame, shifted on a miss
  always_ff @(posedge clk_i) begin
    if (advance && !hit) begin
      for (int i = ENTRIES - 1; i > 0; i--) begin
        entry_page_q[i]  <= entry_page_q[i-1];
        entry_frame_q[i] <= entry_frame_q[i-1];
      end
      entry_page_q[0]  <= in_q.page_index;
      entry_frame_q[0] <= in_q.fill_frame;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  // result channel
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.hit           = rsp_q.hit;
  assign rsp_o.cache_address = rsp_q.cache_address;
  assign rsp_o.victim_valid  = rsp_q.victim_valid;
  assign rsp_o.victim_page   = rsp_q.victim_page;
  assign rsp_o.victim_dirty  = rsp_q.victim_dirty;

endmodule
